// ----- sv/ohlc_pkg.sv -----
`timescale 1ns / 1ps
package ohlc_pkg;

   localparam int INST_W    = 6;
   localparam int TIME_W    = 28;
   localparam int PRICE_W   = 32;
   localparam int HHMM_W    = 12;
   localparam int MIN_W     = 11;
   localparam int IV_W      = 6;
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 2;
   localparam int EXT_W     = 12;

   // shared divider: 12 quotient bits, divisor up to 100000
   localparam int DEN_W = 17;
   localparam int QUO_W = 12;
   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

   // hour and minute digits of an HHMM value
   localparam int HR_W = 6;
   localparam int MM_W = 7;

   localparam logic [DEN_W-1:0]  MS_PER_MINUTE = 17'd100000;
   localparam logic [DEN_W-1:0]  HHMM_RADIX    = 17'd100;
   localparam logic [EXT_W-1:0]  MIN_PER_HOUR  = 12'd60;

   localparam logic [IV_W-1:0]   IV_RESET    = 6'd1;
   localparam logic [HHMM_W-1:0] OPEN_RESET  = 12'd930;
   localparam logic [HHMM_W-1:0] CLOSE_RESET = 12'd1500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INTERVAL,
      CSR_OPEN,
      CSR_CLOSE
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_T,
      ST_DIV_I,
      ST_MUL,
      ST_SESS,
      ST_DIV_M,
      ST_MIN,
      ST_READ,
      ST_UPD
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quo;
      logic [DEN_W-1:0] rem;
   } div_rsp_type;

endpackage

// ----- sv/ohlc_req_if.sv -----
`timescale 1ns / 1ps
interface ohlc_req_if;
   import ohlc_pkg::*;

   logic                valid;
   logic                ready;
   logic                kind;
   logic [INST_W-1:0]   instrument;
   logic [TIME_W-1:0]   time_ms;
   logic [PRICE_W-1:0]  price;

   modport source (output valid, kind, instrument, time_ms, price, input ready);
   modport sink (input valid, kind, instrument, time_ms, price, output ready);
endinterface

// ----- sv/ohlc_rsp_if.sv -----
`timescale 1ns / 1ps
interface ohlc_rsp_if;
   import ohlc_pkg::*;

   logic                valid;
   logic                ready;
   logic [INST_W-1:0]   bar_instrument;
   logic [HHMM_W-1:0]   bar_start;
   logic [MIN_W-1:0]    bar_minute;
   logic [PRICE_W-1:0]  open_price;
   logic [PRICE_W-1:0]  high_price;
   logic [PRICE_W-1:0]  low_price;
   logic [PRICE_W-1:0]  close_price;

   modport source (output valid, bar_instrument, bar_start, bar_minute, open_price,
                    high_price, low_price, close_price, input ready);
   modport sink (input valid, bar_instrument, bar_start, bar_minute, open_price,
                 high_price, low_price, close_price, output ready);
endinterface

// ----- sv/ohlc_div.sv -----
`timescale 1ns / 1ps
module ohlc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ohlc_pkg::div_req_type req,
   output ohlc_pkg::div_rsp_type rsp
);
   import ohlc_pkg::*;

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W+1:0] trial;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {1'b0, rem_ff, num_ff[QUO_W-1]} - {2'b00, den_ff};
      rem_in = trial[DEN_W+1] ? {rem_ff[DEN_W-2:0], num_ff[QUO_W-1]} : trial[DEN_W-1:0];
      num_in = {num_ff[QUO_W-2:0], ~trial[DEN_W+1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= req.rem;
         num_ff <= req.num;
         den_ff <= req.den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = num_ff;
   assign rsp.rem  = rem_ff;

endmodule

// ----- sv/tick_to_ohlc_bar.sv -----
`timescale 1ns / 1ps
// OHLC bar builder: takes one tick or flush word at a time and keeps one open
// bar per instrument. A tick in session takes three 12-step runs of the one
// shared restoring divider (time to HHMM, flooring to the interval, HHMM to
// minutes), then a read and a write of the bar memory; a tick outside the
// session window takes the first two runs, a flush the read and update only.
// A finished bar waits in the output register while the next word is taken.
module tick_to_ohlc_bar #(
   parameter int INSTRUMENTS = 64,
   parameter int PRICE_BITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   ohlc_req_if.sink                          req_chan,
   ohlc_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [ohlc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ohlc_pkg::CSR_W-1:0]        csr_wdata
);
   import ohlc_pkg::*;

   localparam int IDX_W = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
   localparam int SW    = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;

   state_type         state_ff, state_in;
   logic [IV_W-1:0]   iv_ff;
   logic [HHMM_W-1:0] open_ff;
   logic [HHMM_W-1:0] close_ff;
   logic [IV_W-1:0]   iv_eff;

   logic              kind_ff;
   logic [IDX_W-1:0]  addr_ff;
   logic [INST_W-1:0] inst_ff;
   logic [SW-1:0]     price_ff;
   logic [HHMM_W-1:0] bucket_ff;
   logic [MIN_W-1:0]  minute_ff;

   logic [INSTRUMENTS-1:0] act_ff, act_in;

   logic [HHMM_W-1:0] bucket_mem [INSTRUMENTS];
   logic [MIN_W-1:0]  minute_mem [INSTRUMENTS];
   logic [SW-1:0]     open_mem   [INSTRUMENTS];
   logic [SW-1:0]     high_mem   [INSTRUMENTS];
   logic [SW-1:0]     low_mem    [INSTRUMENTS];
   logic [SW-1:0]     close_mem  [INSTRUMENTS];

   logic [HHMM_W-1:0] rd_bucket_ff;
   logic [MIN_W-1:0]  rd_minute_ff;
   logic [SW-1:0]     rd_open_ff;
   logic [SW-1:0]     rd_high_ff;
   logic [SW-1:0]     rd_low_ff;
   logic [SW-1:0]     rd_close_ff;

   logic [HHMM_W-1:0] wr_bucket;
   logic [MIN_W-1:0]  wr_minute;
   logic [SW-1:0]     wr_open;
   logic [SW-1:0]     wr_high;
   logic [SW-1:0]     wr_low;

   logic              rsp_valid_ff;
   logic [INST_W-1:0] rsp_inst_ff;
   logic [HHMM_W-1:0] rsp_start_ff;
   logic [MIN_W-1:0]  rsp_minute_ff;
   logic [SW-1:0]     rsp_open_ff;
   logic [SW-1:0]     rsp_high_ff;
   logic [SW-1:0]     rsp_low_ff;
   logic [SW-1:0]     rsp_close_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [EXT_W-1:0]       inst_ext;
   logic                   in_range;
   logic                   accept;
   logic                   in_session;
   logic [QUO_W+IV_W-1:0]  bucket_prod;
   logic [EXT_W-1:0]       minute_sum;
   logic                   active;
   logic                   new_bar;
   logic                   emit;
   logic                   stall;
   logic                   upd_go;
   logic                   mem_we;

   ohlc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff    <= IV_RESET;
         open_ff  <= OPEN_RESET;
         close_ff <= CLOSE_RESET;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_INTERVAL: iv_ff    <= csr_wdata[IV_W-1:0];
            CSR_OPEN:     open_ff  <= csr_wdata[HHMM_W-1:0];
            CSR_CLOSE:    close_ff <= csr_wdata[HHMM_W-1:0];
            default:      ;
         endcase
      end
   end

   assign iv_eff   = (iv_ff == '0) ? IV_RESET : iv_ff;
   assign inst_ext = EXT_W'(req_chan.instrument);
   assign in_range = ({1'b0, inst_ext} < (EXT_W+1)'(INSTRUMENTS));
   assign accept   = req_chan.valid && req_chan.ready;

   assign in_session  = !((bucket_ff < open_ff) || (bucket_ff > close_ff));
   assign bucket_prod = (QUO_W+IV_W)'(div_rsp.quo) * (QUO_W+IV_W)'(iv_eff);
   assign minute_sum  = EXT_W'(div_rsp.quo[HR_W-1:0]) * MIN_PER_HOUR
                        + EXT_W'(div_rsp.rem[MM_W-1:0]);

   assign active  = act_ff[addr_ff];
   assign new_bar = !active || (rd_bucket_ff != bucket_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && in_range) begin
               state_in = req_chan.kind ? ST_READ : ST_DIV_T;
            end
         end
         ST_DIV_T: begin
            if (div_rsp.done) begin
               state_in = ST_DIV_I;
            end
         end
         ST_DIV_I: begin
            if (div_rsp.done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_SESS;
         ST_SESS: state_in = in_session ? ST_DIV_M : ST_IDLE;
         ST_DIV_M: begin
            if (div_rsp.done) begin
               state_in = ST_MIN;
            end
         end
         ST_MIN:  state_in = ST_READ;
         ST_READ: state_in = ST_UPD;
         ST_UPD: begin
            if (!stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_chan.ready = 1'b0;
      div_req        = '0;
      emit           = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            div_req.start  = accept && in_range && !req_chan.kind;
            div_req.rem    = DEN_W'(req_chan.time_ms[TIME_W-1:QUO_W]);
            div_req.num    = req_chan.time_ms[QUO_W-1:0];
            div_req.den    = MS_PER_MINUTE;
         end
         ST_DIV_T: begin
            div_req.start = div_rsp.done;
            div_req.num   = div_rsp.quo;
            div_req.den   = DEN_W'(iv_eff);
         end
         ST_SESS: begin
            div_req.start = in_session;
            div_req.num   = bucket_ff;
            div_req.den   = HHMM_RADIX;
         end
         ST_UPD: begin
            emit = active && (kind_ff || new_bar);
         end
         default: ;
      endcase
   end

   // hold an emitting update while a finished bar still waits downstream
   assign stall  = emit && rsp_valid_ff && !rsp_chan.ready;
   assign upd_go = (state_ff == ST_UPD) && !stall;
   assign mem_we = upd_go && !kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         act_ff   <= '0;
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
      end
   end

   always_comb begin
      act_in = act_ff;
      if (upd_go) begin
         act_in[addr_ff] = !kind_ff;
      end
   end

   // item capture and bucket arithmetic
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_chan.kind;
         addr_ff  <= inst_ext[IDX_W-1:0];
         inst_ff  <= req_chan.instrument;
         price_ff <= req_chan.price[SW-1:0];
      end
      if (state_ff == ST_MUL) begin
         bucket_ff <= bucket_prod[HHMM_W-1:0];
      end
      if (state_ff == ST_MIN) begin
         minute_ff <= minute_sum[MIN_W-1:0];
      end
   end

   // new bar opens at the tick price, else fold the price in
   always_comb begin
      wr_bucket = new_bar ? bucket_ff : rd_bucket_ff;
      wr_minute = new_bar ? minute_ff : rd_minute_ff;
      wr_open   = new_bar ? price_ff : rd_open_ff;
      wr_high   = (new_bar || (price_ff > rd_high_ff)) ? price_ff : rd_high_ff;
      wr_low    = (new_bar || (price_ff < rd_low_ff)) ? price_ff : rd_low_ff;
   end

   // bar memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bucket_mem[addr_ff] <= wr_bucket;
         minute_mem[addr_ff] <= wr_minute;
         open_mem[addr_ff]   <= wr_open;
         high_mem[addr_ff]   <= wr_high;
         low_mem[addr_ff]    <= wr_low;
         close_mem[addr_ff]  <= price_ff;
      end
      if (state_ff == ST_READ) begin
         rd_bucket_ff <= bucket_mem[addr_ff];
         rd_minute_ff <= minute_mem[addr_ff];
         rd_open_ff   <= open_mem[addr_ff];
         rd_high_ff   <= high_mem[addr_ff];
         rd_low_ff    <= low_mem[addr_ff];
         rd_close_ff  <= close_mem[addr_ff];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (upd_go && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_go && emit) begin
         rsp_inst_ff   <= inst_ff;
         rsp_start_ff  <= rd_bucket_ff;
         rsp_minute_ff <= rd_minute_ff;
         rsp_open_ff   <= rd_open_ff;
         rsp_high_ff   <= rd_high_ff;
         rsp_low_ff    <= rd_low_ff;
         rsp_close_ff  <= rd_close_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.bar_instrument = rsp_inst_ff;
   assign rsp_chan.bar_start      = rsp_start_ff;
   assign rsp_chan.bar_minute     = rsp_minute_ff;
   assign rsp_chan.open_price     = PRICE_W'(rsp_open_ff);
   assign rsp_chan.high_price     = PRICE_W'(rsp_high_ff);
   assign rsp_chan.low_price      = PRICE_W'(rsp_low_ff);
   assign rsp_chan.close_price    = PRICE_W'(rsp_close_ff);

endmodule
